// ----- src/adjacency_matrix_graph_table_core_macros.svh -----
// Assertion macros shared by the graph table RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ADJACENCY_MATRIX_GRAPH_TABLE_CORE_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_TABLE_CORE_MACROS_SVH

// Clocked check, off while reset is high
`define AMG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset
`define AMG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/amg_pkg.sv -----
// Shared types and constants for the directed graph table.
// No dependencies; used by every module of the block but amg_fifo.
package amg_pkg;

  // Defaults for the top level parameters
  localparam int MAX_VERTICES_DEF = 16;
  localparam int LABEL_BITS_DEF   = 32;

  // Label port width and the width labels are sign-extended to
  localparam int IN_LABEL_BITS = 32;
  localparam int EXT_BITS      = 64;

  // Depth of the command and result queues
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_ADD_VERTEX = 2'd0,
    OP_ADD_EDGE   = 2'd1,
    OP_DEL_EDGE   = 2'd2,
    OP_QUERY      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUP       = 3'd2,
    ST_NO_VERTEX = 3'd3,
    ST_NO_EDGE   = 3'd4
  } status_t;

  // Control from the command queue to the executor
  typedef struct packed {
    logic valid;
    op_t  op;
  } cmd_ctl_t;

  // One result word
  typedef struct packed {
    status_t status;
    logic    edge_present;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);

endpackage

// ----- src/amg_fifo.sv -----
// Small register-based queue with push/full and pop/empty sides.
// No package dependencies; used for the command and result queues.
module amg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [FW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == FW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- src/amg_front.sv -----
// Front end: takes command words, decodes the op, normalizes both labels
// and queues them for the executor. Uses amg_pkg and amg_fifo.
module amg_front #(
  parameter int LABEL_BITS = amg_pkg::LABEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        op,
  input  logic signed [amg_pkg::IN_LABEL_BITS-1:0] label_a,
  input  logic signed [amg_pkg::IN_LABEL_BITS-1:0] label_b,
  output amg_pkg::cmd_ctl_t                 cmd_ctl,
  output logic [LABEL_BITS-1:0]             cmd_label_a,
  output logic [LABEL_BITS-1:0]             cmd_label_b,
  input  logic                              cmd_pop
);

  localparam int IB = amg_pkg::IN_LABEL_BITS;
  localparam int XB = amg_pkg::EXT_BITS;
  localparam int CMD_BITS = 2 + 2 * LABEL_BITS;

  logic [XB-1:0]       ext_a;
  logic [XB-1:0]       ext_b;
  logic [CMD_BITS-1:0] word_in;
  logic [CMD_BITS-1:0] word_out;
  logic                q_empty;

  // sign-extend, then keep the low LABEL_BITS bits
  assign ext_a   = {{(XB - IB){label_a[IB-1]}}, label_a};
  assign ext_b   = {{(XB - IB){label_b[IB-1]}}, label_b};
  assign word_in = {op, ext_a[LABEL_BITS-1:0], ext_b[LABEL_BITS-1:0]};

  amg_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (amg_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (word_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (word_out),
    .empty (q_empty)
  );

  // unpack the queued word
  assign cmd_ctl.valid = !q_empty;
  assign cmd_ctl.op    = amg_pkg::op_t'(word_out[CMD_BITS-1 -: 2]);
  assign cmd_label_a   = word_out[2*LABEL_BITS-1 -: LABEL_BITS];
  assign cmd_label_b   = word_out[LABEL_BITS-1:0];

endmodule

// ----- src/amg_back.sv -----
// Back end: label lookup against the vertex table, then a read-modify-write
// of one edge row. Uses amg_pkg and the assertion macros header.
`include "adjacency_matrix_graph_table_core_macros.svh"

module amg_back #(
  parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF,
  parameter int LABEL_BITS   = amg_pkg::LABEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  amg_pkg::cmd_ctl_t     cmd_ctl,
  input  logic [LABEL_BITS-1:0] cmd_label_a,
  input  logic [LABEL_BITS-1:0] cmd_label_b,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output amg_pkg::result_t      res_word
);

  localparam int IDXW = $clog2(MAX_VERTICES);
  localparam int CW   = $clog2(MAX_VERTICES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_READ = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t                  state;
  amg_pkg::op_t            op_q;
  logic [LABEL_BITS-1:0]   lab_a;
  logic [LABEL_BITS-1:0]   lab_b;
  logic [LABEL_BITS-1:0]   labels [MAX_VERTICES];
  logic [CW-1:0]           count;

  logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] row_q;
  logic                    row_q_ok;

  logic [IDXW-1:0]         o_idx;
  logic [IDXW-1:0]         d_idx;
  logic                    found_a;
  logic                    found_b;

  logic [MAX_VERTICES-1:0] hit_a;
  logic [MAX_VERTICES-1:0] hit_b;
  logic [IDXW-1:0]         idx_a;
  logic [IDXW-1:0]         idx_b;

  logic [MAX_VERTICES-1:0] row_cur;
  logic [MAX_VERTICES-1:0] bit_d;
  logic [MAX_VERTICES-1:0] row_new;
  logic                    has_edge;
  logic                    row_we;
  logic                    lbl_we;
  amg_pkg::status_t        status_c;
  logic                    present_c;

  // parallel compare against occupied slots
  always_comb begin
    hit_a = '0;
    hit_b = '0;
    idx_a = '0;
    idx_b = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      hit_a[i] = (CW'(i) < count) && (labels[i] == lab_a);
      hit_b[i] = (CW'(i) < count) && (labels[i] == lab_b);
      if (hit_a[i]) idx_a = idx_a | IDXW'(i);
      if (hit_b[i]) idx_b = idx_b | IDXW'(i);
    end
  end

  // execute: decide status and the row / table update
  assign row_cur  = row_q_ok ? row_q : '0;
  assign bit_d    = {{(MAX_VERTICES - 1){1'b0}}, 1'b1} << d_idx;
  assign has_edge = |(row_cur & bit_d);

  always_comb begin
    status_c  = amg_pkg::ST_OK;
    present_c = 1'b0;
    row_new   = row_cur;
    row_we    = 1'b0;
    lbl_we    = 1'b0;
    unique case (op_q)
      amg_pkg::OP_ADD_VERTEX: begin
        if (count == CW'(MAX_VERTICES)) begin
          status_c = amg_pkg::ST_FULL;
        end else if (found_a) begin
          status_c = amg_pkg::ST_DUP;
        end else begin
          lbl_we = 1'b1;
        end
      end
      default: begin
        if (!(found_a && found_b)) begin
          status_c = amg_pkg::ST_NO_VERTEX;
        end else begin
          case (op_q)
            amg_pkg::OP_ADD_EDGE: begin
              row_new = row_cur | bit_d;
              row_we  = 1'b1;
            end
            amg_pkg::OP_DEL_EDGE: begin
              if (has_edge) begin
                row_new = row_cur & ~bit_d;
                row_we  = 1'b1;
              end else begin
                status_c = amg_pkg::ST_NO_EDGE;
              end
            end
            default: begin
              present_c = has_edge;
            end
          endcase
        end
      end
    endcase
    if (state != S_EXEC) begin
      row_we = 1'b0;
      lbl_we = 1'b0;
    end
  end

  assign cmd_pop               = (state == S_IDLE) && cmd_ctl.valid && !res_full;
  assign res_push              = (state == S_EXEC);
  assign res_word.status       = status_c;
  assign res_word.edge_present = present_c;

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      row_valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (cmd_pop) state <= S_LOOK;
        S_LOOK: state <= S_READ;
        S_READ: state <= S_EXEC;
        S_EXEC: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (lbl_we) begin
        count <= count + 1'b1;
      end
      if (row_we) begin
        row_valid[o_idx] <= 1'b1;
      end
    end
  end

  // command and lookup payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      op_q  <= cmd_ctl.op;
      lab_a <= cmd_label_a;
      lab_b <= cmd_label_b;
    end
    if (state == S_LOOK) begin
      o_idx   <= idx_a;
      d_idx   <= idx_b;
      found_a <= |hit_a;
      found_b <= |hit_b;
    end
    if (lbl_we) begin
      labels[count[IDXW-1:0]] <= lab_a;
    end
  end

  // edge row memory, registered read
  always_ff @(posedge clk) begin
    if (row_we) begin
      rows[o_idx] <= row_new;
    end
    if (state == S_READ) begin
      row_q    <= rows[o_idx];
      row_q_ok <= row_valid[o_idx];
    end
  end

  `AMG_ASSERT(a_count_max, count <= CW'(MAX_VERTICES), "vertex count above capacity")
  `AMG_ASSERT(a_count_step, !$stable(count) |-> (count == $past(count) + 1'b1) && $past(state == S_EXEC), "vertex count changed outside execute")
  `AMG_ASSERT(a_pop_space, cmd_pop |=> !res_full || $past(res_full) == 1'b0, "command taken without result space")
  `AMG_ASSERT(a_exec_once, state == S_EXEC |=> state == S_IDLE, "execute did not return to idle")
  `AMG_ASSERT_ALWAYS(a_reset_idle, rst |=> state == S_IDLE && count == '0, "reset did not clear control")

endmodule

// ----- src/adjacency_matrix_graph_table_core.sv -----
// Directed graph table: up to MAX_VERTICES distinct labels and a bit matrix
// of edges, driven as a queue on both sides. Each command word gives exactly
// one result word. The executor handles one command at a time, in order:
// take from queue, parallel label lookup, edge row read, row update and
// result, as the registered read and read-modify-write of the edge row
// memory require; a 2-deep command queue and a 2-deep result queue let the
// input and output sides stall on their own. The edge matrix reads as empty
// right after reset without a clearing pass. Uses amg_pkg, amg_fifo,
// amg_front and amg_back.
module adjacency_matrix_graph_table_core #(
  parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF,
  parameter int LABEL_BITS   = amg_pkg::LABEL_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  output logic                                     full,
  input  logic [1:0]                               op,
  input  logic signed [amg_pkg::IN_LABEL_BITS-1:0] label_a,
  input  logic signed [amg_pkg::IN_LABEL_BITS-1:0] label_b,
  output logic                                     empty,
  input  logic                                     pop,
  output logic [2:0]                               status,
  output logic                                     edge_present
);

  amg_pkg::cmd_ctl_t                  cmd_ctl;
  logic [LABEL_BITS-1:0]              cmd_label_a;
  logic [LABEL_BITS-1:0]              cmd_label_b;
  logic                               cmd_pop;
  logic                               res_full;
  logic                               res_push;
  amg_pkg::result_t                   res_word;
  logic [amg_pkg::RESULT_BITS-1:0]    res_out;
  amg_pkg::result_t                   res_head;

  amg_front #(
    .LABEL_BITS (LABEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .op          (op),
    .label_a     (label_a),
    .label_b     (label_b),
    .cmd_ctl     (cmd_ctl),
    .cmd_label_a (cmd_label_a),
    .cmd_label_b (cmd_label_b),
    .cmd_pop     (cmd_pop)
  );

  amg_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .LABEL_BITS   (LABEL_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_ctl     (cmd_ctl),
    .cmd_label_a (cmd_label_a),
    .cmd_label_b (cmd_label_b),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_word    (res_word)
  );

  // result queue
  amg_fifo #(
    .WIDTH (amg_pkg::RESULT_BITS),
    .DEPTH (amg_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_word),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign res_head     = res_out;
  assign status       = res_head.status;
  assign edge_present = res_head.edge_present;

endmodule

// ----- bench/amg_bench_pkg.sv -----
// Scoreboard for the directed graph table bench: a shadow copy of the label
// table and edge matrix that predicts one status word per command.
// Depends on amg_pkg for the op and status codes and the default sizes.
`timescale 1ns / 100ps

package amg_bench_pkg;
  import amg_pkg::*;

  localparam int VERTICES = MAX_VERTICES_DEF;

  // One predicted result word
  typedef struct {
    status_t status;
    logic    edge_present;
  } outcome_t;

  class graph_shadow;
    logic [IN_LABEL_BITS-1:0] labels [VERTICES];
    int unsigned              used_slots;
    logic [VERTICES-1:0]      rows [VERTICES];
    outcome_t                 awaited [$];
    int unsigned              mismatches;

    function new();
      used_slots = 0;
      mismatches = 0;
      foreach (rows[i]) rows[i] = '0;
      foreach (labels[i]) labels[i] = '0;
    endfunction

    // Slot holding the label, -1 when absent; only occupied slots are looked at
    function int find_slot(logic [IN_LABEL_BITS-1:0] lbl);
      int hit;
      hit = -1;
      for (int i = 0; i < used_slots; i++) begin
        if (labels[i] == lbl) hit = i;
      end
      return hit;
    endfunction

    // Apply an accepted command to the shadow state and queue its status word
    function void note_command(op_t cmd, logic [IN_LABEL_BITS-1:0] a,
                               logic [IN_LABEL_BITS-1:0] b);
      outcome_t res;
      int       o;
      int       d;
      logic     has;
      res.status       = ST_OK;
      res.edge_present = 1'b0;
      if (cmd == OP_ADD_VERTEX) begin
        if (used_slots >= VERTICES) begin
          res.status = ST_FULL;
        end else if (find_slot(a) >= 0) begin
          res.status = ST_DUP;
        end else begin
          labels[used_slots] = a;
          used_slots++;
        end
      end else begin
        o = find_slot(a);
        d = find_slot(b);
        if (o < 0 || d < 0) begin
          res.status = ST_NO_VERTEX;
        end else begin
          has = rows[o][d];
          case (cmd)
            OP_ADD_EDGE: begin
              rows[o][d] = 1'b1;
            end
            OP_DEL_EDGE: begin
              if (has) rows[o][d] = 1'b0;
              else res.status = ST_NO_EDGE;
            end
            default: begin
              res.edge_present = has;
            end
          endcase
        end
      end
      awaited.push_back(res);
    endfunction

    // Compare a popped word against the oldest prediction
    function void check_result(logic [2:0] st, logic ep);
      outcome_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected word status=%0d edge_present=%0d", st, ep);
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status || ep !== want.edge_present) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status exp %0d got %0d, edge_present exp %0d got %0d",
                   want.status, st, want.edge_present, ep);
      end
    endfunction
  endclass

endpackage

// ----- bench/tb_adjacency_matrix_graph_table_core.sv -----
// Bench top for adjacency_matrix_graph_table_core: directed and random graph
// commands through the push/pop queues, checked by amg_bench_pkg::graph_shadow.
// Depends on amg_pkg, amg_bench_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_adjacency_matrix_graph_table_core;
  import amg_pkg::*;
  import amg_bench_pkg::*;

  localparam int POOL_SIZE   = 20;
  localparam int PHASE_WORDS = 283;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  op = 2'd0;
  logic [31:0] label_a = '0;
  logic [31:0] label_b = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status;
  logic        edge_present;

  graph_shadow shadow;
  logic [31:0] label_pool [POOL_SIZE];
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          cycle_count = 0;

  adjacency_matrix_graph_table_core dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .label_a      (label_a),
    .label_b      (label_b),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .edge_present (edge_present)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL adjacency_matrix_graph_table_core");
      $finish;
    end
  end

  // Push one command word, holding it until the queue takes it
  task automatic send_word(op_t cmd, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    op      <= cmd;
    label_a <= a;
    label_b <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    shadow.note_command(cmd, a, b);
  endtask

  // Mostly labels from a few hot slots, then the whole pool, a few unknown
  function automatic logic [31:0] pick_label();
    int r;
    r = $urandom_range(99);
    if (r < 45) return label_pool[$urandom_range(5)];
    if (r < 90) return label_pool[$urandom_range(POOL_SIZE-1)];
    return $urandom;
  endfunction

  task automatic send_random_word();
    op_t cmd;
    if ($urandom_range(99) < 15) cmd = OP_ADD_VERTEX;
    else cmd = op_t'($urandom_range(3, 1));
    send_word(cmd, pick_label(), pick_label());
  endtask

  // Result side: pop at random, check each word taken
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      pop <= ($urandom_range(99) >= stall_pct);
      @(posedge clk);
      if (pop && !empty) shadow.check_result(status, edge_present);
    end
  end

  // Main sequence
  initial begin
    logic [31:0] unknown;
    int          idle_by_phase [4];
    int          stall_by_phase [4];
    shadow = new();
    label_pool[0] = 32'h8000_0000;
    label_pool[1] = 32'h7fff_ffff;
    label_pool[2] = 32'h0000_0000;
    label_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) label_pool[i] = $urandom;
    unknown = 32'h5a5a_a5a5;
    idle_by_phase  = '{0, 75, 0, 20};
    stall_by_phase = '{0, 0, 75, 20};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme labels, duplicate, each edge op and its corner cases
    send_word(OP_ADD_VERTEX, label_pool[0], $urandom);
    send_word(OP_ADD_VERTEX, label_pool[1], $urandom);
    send_word(OP_ADD_VERTEX, label_pool[2], $urandom);
    send_word(OP_ADD_VERTEX, label_pool[3], $urandom);
    send_word(OP_ADD_VERTEX, label_pool[1], $urandom);
    send_word(OP_ADD_EDGE, label_pool[0], label_pool[1]);
    send_word(OP_ADD_EDGE, label_pool[0], label_pool[1]);
    send_word(OP_ADD_EDGE, label_pool[3], label_pool[3]);
    send_word(OP_QUERY, label_pool[0], label_pool[1]);
    send_word(OP_QUERY, label_pool[1], label_pool[0]);
    send_word(OP_QUERY, label_pool[3], label_pool[3]);
    send_word(OP_DEL_EDGE, label_pool[0], label_pool[1]);
    send_word(OP_DEL_EDGE, label_pool[0], label_pool[1]);
    send_word(OP_QUERY, label_pool[0], label_pool[1]);
    send_word(OP_ADD_EDGE, label_pool[0], unknown);
    send_word(OP_ADD_EDGE, unknown, label_pool[2]);
    send_word(OP_DEL_EDGE, unknown, label_pool[2]);
    send_word(OP_QUERY, label_pool[2], unknown);

    // Random phases; the table fills early, so later inserts mostly bounce
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      repeat (PHASE_WORDS) send_random_word();
    end

    // Drain
    push <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
      $display("PASS adjacency_matrix_graph_table_core");
    end else begin
      $display("FAIL adjacency_matrix_graph_table_core");
    end
    $finish;
  end

endmodule

// ----- adjacency_matrix_graph_table_core.f -----
+incdir+src
src/amg_pkg.sv
src/amg_fifo.sv
src/amg_front.sv
src/amg_back.sv
src/adjacency_matrix_graph_table_core.sv
bench/amg_bench_pkg.sv
bench/tb_adjacency_matrix_graph_table_core.sv
